// ===== rtl/uvwt_pkg.sv =====
// Shared types, constants and the whitespace classifier for the UTF-8 trim block.
`default_nettype none

package uvwt_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    // Width of the sequence currently being decoded.
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_W1   = 3'd1;
    localparam logic [2:0] SEQ_W2   = 3'd2;
    localparam logic [2:0] SEQ_W3   = 3'd3;
    localparam logic [2:0] SEQ_W4   = 3'd4;

    // Lead byte ranges.
    localparam logic [7:0] LEAD2_MIN = 8'hc2;
    localparam logic [7:0] LEAD2_MAX = 8'hdf;
    localparam logic [7:0] LEAD3_MIN = 8'he0;
    localparam logic [7:0] LEAD3_MAX = 8'hef;
    localparam logic [7:0] LEAD4_MIN = 8'hf0;
    localparam logic [7:0] LEAD4_MAX = 8'hf4;

    // Codepoint limits.
    localparam logic [20:0] CP_MIN3    = 21'h000800;
    localparam logic [20:0] CP_MIN4    = 21'h010000;
    localparam logic [20:0] CP_MAX     = 21'h10ffff;
    localparam logic [20:0] CP_SURR_LO = 21'h00d800;
    localparam logic [20:0] CP_SURR_HI = 21'h00dfff;

    // Per-byte event from the decoder to the offset tracker.
    typedef struct packed {
        logic lead;      // byte opened a new sequence (valid or not)
        logic cp_ok;     // a well-formed codepoint finished on this byte
        logic nonspace;  // that codepoint is outside the strip set
        logic error;     // string is invalid as of this byte
    } dec_ev_t;

    // Result item as it leaves the tracker.
    typedef struct packed {
        status_t     status;
        logic [15:0] trim_begin;
        logic [15:0] trim_end;
        logic [15:0] total_length;
    } result_t;

    function automatic logic is_strip_space(input logic [20:0] c);
        logic hit;
        hit = (c >= 21'h000009 && c <= 21'h00000d) ||
              (c >= 21'h00001c && c <= 21'h000020) ||
              (c == 21'h000085) || (c == 21'h0000a0) || (c == 21'h001680) ||
              (c >= 21'h002000 && c <= 21'h00200a) ||
              (c == 21'h002028) || (c == 21'h002029) ||
              (c == 21'h00202f) || (c == 21'h00205f) || (c == 21'h003000);
        return hit;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/uvwt_decode.sv =====
// Strict UTF-8 decoder: tracks the open sequence and flags codepoints and errors per byte.
`default_nettype none

module uvwt_decode
    import uvwt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output dec_ev_t         ev
);

    logic [1:0]  rem_reg, rem_next;
    logic [2:0]  width_reg, width_next;
    logic [20:0] pv_reg, pv_next;
    logic        err_reg, err_next;
    logic        cp_end;
    logic        cp_bad;

    always_comb
    begin
        rem_next   = rem_reg;
        width_next = width_reg;
        pv_next    = pv_reg;
        err_next   = err_reg;
        cp_end     = 1'b0;
        cp_bad     = 1'b0;
        ev         = '0;

        if (step)
        begin
            if (!err_reg)
            begin
                if (rem_reg == 2'd0)
                begin
                    ev.lead = 1'b1;
                    priority if (!data_byte[7])
                    begin
                        width_next = SEQ_W1;
                        pv_next    = {13'd0, data_byte};
                        cp_end     = 1'b1;
                    end
                    else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX)
                    begin
                        width_next = SEQ_W2;
                        pv_next    = {16'd0, data_byte[4:0]};
                        rem_next   = 2'd1;
                    end
                    else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX)
                    begin
                        width_next = SEQ_W3;
                        pv_next    = {17'd0, data_byte[3:0]};
                        rem_next   = 2'd2;
                    end
                    else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX)
                    begin
                        width_next = SEQ_W4;
                        pv_next    = {18'd0, data_byte[2:0]};
                        rem_next   = 2'd3;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else if (data_byte[7:6] != 2'b10)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    pv_next  = {pv_reg[14:0], data_byte[5:0]};
                    rem_next = rem_reg - 2'd1;
                    cp_end   = (rem_reg == 2'd1);
                end

                if (cp_end)
                begin
                    cp_bad = (width_next == SEQ_W3 && pv_next < CP_MIN3) ||
                             (width_next == SEQ_W4 && pv_next < CP_MIN4) ||
                             (pv_next > CP_MAX) ||
                             (pv_next >= CP_SURR_LO && pv_next <= CP_SURR_HI);
                    if (cp_bad)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        ev.cp_ok    = 1'b1;
                        ev.nonspace = !is_strip_space(pv_next);
                    end
                end
            end

            // A sequence still open at the end of the string is an error.
            if (last_byte && rem_next != 2'd0)
            begin
                err_next = 1'b1;
            end

            ev.error = err_next;

            if (last_byte)
            begin
                rem_next   = 2'd0;
                width_next = SEQ_NONE;
                pv_next    = '0;
                err_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= 2'd0;
            width_reg <= SEQ_NONE;
            pv_reg    <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            rem_reg   <= rem_next;
            width_reg <= width_next;
            pv_reg    <= pv_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uvwt_bounds.sv =====
// Byte counter and trim offset tracker; forms the result fields on the final byte.
`default_nettype none

module uvwt_bounds
    import uvwt_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire logic    last_byte,
    input  wire dec_ev_t ev,
    output result_t      res
);

    localparam logic [LENGTH_BITS-1:0] MAXLEN = {LENGTH_BITS{1'b1}};

    logic [LENGTH_BITS:0]   count_reg, count_next, count_upd, pos_inc;
    logic [LENGTH_BITS-1:0] start_reg, start_next, start_upd;
    logic [LENGTH_BITS-1:0] first_reg, first_next, first_upd;
    logic [LENGTH_BITS-1:0] end_reg, end_next, end_upd;
    logic                   seen_reg, seen_next, seen_upd;
    logic [LENGTH_BITS-1:0] pos_sat, inc_sat, cur_start, len_sat;
    logic                   hit;

    always_comb
    begin
        pos_inc   = count_reg + {{LENGTH_BITS{1'b0}}, 1'b1};
        pos_sat   = count_reg[LENGTH_BITS] ? MAXLEN : count_reg[LENGTH_BITS-1:0];
        inc_sat   = pos_inc[LENGTH_BITS] ? MAXLEN : pos_inc[LENGTH_BITS-1:0];

        // The counter stops one past the largest offset so that too-long is visible.
        count_upd = step ? (count_reg[LENGTH_BITS] ? count_reg : pos_inc) : count_reg;
        start_upd = (step && ev.lead) ? pos_sat : start_reg;
        cur_start = ev.lead ? pos_sat : start_reg;

        hit       = step && ev.cp_ok && ev.nonspace;
        first_upd = (hit && !seen_reg) ? cur_start : first_reg;
        end_upd   = hit ? inc_sat : end_reg;
        seen_upd  = seen_reg || hit;

        len_sat   = count_upd[LENGTH_BITS] ? MAXLEN : count_upd[LENGTH_BITS-1:0];

        res.total_length = 16'(len_sat);
        if (ev.error)
        begin
            res.status     = STATUS_INVALID;
            res.trim_begin = 16'd0;
            res.trim_end   = 16'd0;
        end
        else
        begin
            res.status     = count_upd[LENGTH_BITS] ? STATUS_TOO_LONG : STATUS_OK;
            res.trim_begin = seen_upd ? 16'(first_upd) : 16'(len_sat);
            res.trim_end   = seen_upd ? 16'(end_upd) : 16'(len_sat);
        end

        if (step && last_byte)
        begin
            count_next = '0;
            start_next = '0;
            first_next = '0;
            end_next   = '0;
            seen_next  = 1'b0;
        end
        else
        begin
            count_next = count_upd;
            start_next = start_upd;
            first_next = first_upd;
            end_next   = end_upd;
            seen_next  = seen_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            start_reg <= '0;
            first_reg <= '0;
            end_reg   <= '0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            start_reg <= start_next;
            first_reg <= first_next;
            end_reg   <= end_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/utf8_validate_whitespace_trim_top.sv =====
// Top level: input register, per-byte decode and offset tracking, result register.
// Throughput: one byte per clock cycle, sustained, including back-to-back strings.
// The edge that accepts the final byte loads the input register; the result register is then
// loaded through decode and tracking once it is free to take the result.
// Strings of any length are taken byte by byte; a held result stalls only the final byte.
// Reset (rst_n low, asynchronous) clears the decoder, counters and both valid flags.
`default_nettype none

module utf8_validate_whitespace_trim_top
    import uvwt_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [1:0]       status,
    output logic [15:0]      trim_begin,
    output logic [15:0]      trim_end,
    output logic [15:0]      total_length
);

    logic        in_vld_reg, in_vld_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        res_vld_reg, res_vld_next;
    result_t     res_reg;
    result_t     res_comb;
    dec_ev_t     ev;
    logic        res_free;
    logic        step;
    logic        take;

    // A final byte may only be processed when the result register can take its request.
    assign res_free   = !res_vld_reg || result_ready;
    assign step       = in_vld_reg && (!in_last_reg || res_free);
    assign byte_ready = !in_vld_reg || step;
    assign take       = byte_valid && byte_ready;

    always_comb
    begin
        in_vld_next = take ? 1'b1 : (step ? 1'b0 : in_vld_reg);
        if (step && in_last_reg)
        begin
            res_vld_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_vld_next = 1'b0;
        end
        else
        begin
            res_vld_next = res_vld_reg;
        end
    end

    uvwt_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .ev        (ev)
    );

    uvwt_bounds #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_bounds (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .last_byte (in_last_reg),
        .ev        (ev),
        .res       (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (step && in_last_reg)
        begin
            res_reg <= res_comb;
        end
    end

    assign result_valid = res_vld_reg;
    assign status       = res_reg.status;
    assign trim_begin   = res_reg.trim_begin;
    assign trim_end     = res_reg.trim_end;
    assign total_length = res_reg.total_length;

endmodule

`default_nettype wire

// ===== rtl/uvwt_checker.sv =====
// Port-level checker for the UTF-8 trim block, bound to the top level.
`default_nettype none

module uvwt_checker
    import uvwt_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        byte_valid,
    input wire logic        byte_ready,
    input wire logic [7:0]  data_byte,
    input wire logic        last_byte,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic [1:0]  status,
    input wire logic [15:0] trim_begin,
    input wire logic [15:0] trim_end,
    input wire logic [15:0] total_length
);

    // A stalled result request keeps its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(status) && $stable(trim_begin) &&
            $stable(trim_end) && $stable(total_length))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> status != 2'd3)
        else $error("undefined status code");

    // An invalid string reports zero bounds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == STATUS_INVALID |-> trim_begin == 16'd0 && trim_end == 16'd0)
        else $error("invalid string with nonzero bounds");

    // For a good string the bounds are ordered and lie inside the string.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == STATUS_OK && LENGTH_BITS <= 16 |->
            trim_begin <= trim_end && trim_end <= total_length && total_length != 16'd0)
        else $error("trim bounds out of order");

    // A result can only follow an accepted final byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(byte_valid && byte_ready && last_byte, 2) ||
                                $past(!byte_ready, 1))
        else $error("result without a final byte");

endmodule

bind utf8_validate_whitespace_trim_top uvwt_checker #(
    .LENGTH_BITS (LENGTH_BITS)
) u_uvwt_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the UTF-8 validate and whitespace trim block.
`timescale 1ns / 1ps

module tb_top;
    import uvwt_pkg::*;

    localparam int unsigned LEN_MAX         = 65535;
    localparam int unsigned CLK_HALF        = 5;
    localparam int unsigned CYCLE_LIMIT     = 200_000;
    localparam int unsigned HOLD_OFF_CYCLES = 200;
    localparam int unsigned RANDOM_BYTES    = 800;
    localparam int unsigned QUIET_AFTER     = 650;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int          DIR_ROWS        = 26;

    typedef enum logic [1:0] {
        NOISE_RAW,
        NOISE_FLIP,
        NOISE_CUT,
        NOISE_BAD_FORM
    } noise_t;

    // One directed string: bytes right-aligned, first byte most significant.
    typedef struct packed {
        logic [3:0]  nbytes;
        logic [63:0] text;
        logic        typed;
        result_t     report;
    } dir_row_t;

    localparam result_t NO_REPORT = '{STATUS_OK, 16'd0, 16'd0, 16'd0};

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic [7:0]  data_byte    = 8'd0;
    logic        last_byte    = 1'b0;
    logic        result_ready = 1'b0;
    logic        byte_ready;
    logic        result_valid;
    logic [1:0]  status;
    logic [15:0] trim_begin;
    logic [15:0] trim_end;
    logic [15:0] total_length;

    // Decoder state mirrored by the predictor.
    logic [1:0]  cont_left;
    logic [2:0]  seq_width;
    logic [20:0] cp_value;
    logic [15:0] cp_start;
    logic [16:0] bytes_seen;
    logic [15:0] first_begin;
    logic [15:0] last_end;
    logic        any_nonspace;
    logic        bad_utf8;

    result_t     pending_reports[$];
    logic [7:0]  text_bytes[$];
    int unsigned bytes_sent   = 0;
    int unsigned fail_count   = 0;
    logic        sender_gaps  = 1'b1;
    logic        sink_gaps    = 1'b1;
    logic        hold_off_req = 1'b0;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{4'd1, 64'h00,             1'b1, '{STATUS_OK,      16'd0, 16'd1, 16'd1}},
        '{4'd2, 64'h7f20,           1'b1, '{STATUS_OK,      16'd0, 16'd1, 16'd2}},
        '{4'd1, 64'h20,             1'b1, '{STATUS_OK,      16'd1, 16'd1, 16'd1}},
        '{4'd3, 64'h090d1c,         1'b0, NO_REPORT},
        '{4'd3, 64'h206120,         1'b0, NO_REPORT},
        '{4'd2, 64'hc285,           1'b0, NO_REPORT},
        '{4'd3, 64'hc2a041,         1'b0, NO_REPORT},
        '{4'd2, 64'hc280,           1'b1, '{STATUS_OK,      16'd0, 16'd2, 16'd2}},
        '{4'd2, 64'hdfbf,           1'b1, '{STATUS_OK,      16'd0, 16'd2, 16'd2}},
        '{4'd3, 64'he19a80,         1'b0, NO_REPORT},
        '{4'd7, 64'he2808a20e2808b, 1'b0, NO_REPORT},
        '{4'd3, 64'he38080,         1'b0, NO_REPORT},
        '{4'd7, 64'he280a861e280a9, 1'b0, NO_REPORT},
        '{4'd3, 64'he0a080,         1'b1, '{STATUS_OK,      16'd0, 16'd3, 16'd3}},
        '{4'd3, 64'he09fbf,         1'b1, '{STATUS_INVALID, 16'd0, 16'd0, 16'd3}},
        '{4'd3, 64'heda080,         1'b1, '{STATUS_INVALID, 16'd0, 16'd0, 16'd3}},
        '{4'd3, 64'hed9fbf,         1'b0, NO_REPORT},
        '{4'd4, 64'hf0908080,       1'b1, '{STATUS_OK,      16'd0, 16'd4, 16'd4}},
        '{4'd4, 64'hf08fbfbf,       1'b1, '{STATUS_INVALID, 16'd0, 16'd0, 16'd4}},
        '{4'd4, 64'hf48fbfbf,       1'b1, '{STATUS_OK,      16'd0, 16'd4, 16'd4}},
        '{4'd4, 64'hf4908080,       1'b1, '{STATUS_INVALID, 16'd0, 16'd0, 16'd4}},
        '{4'd1, 64'h80,             1'b1, '{STATUS_INVALID, 16'd0, 16'd0, 16'd1}},
        '{4'd2, 64'hc1bf,           1'b1, '{STATUS_INVALID, 16'd0, 16'd0, 16'd2}},
        '{4'd2, 64'hf5ff,           1'b1, '{STATUS_INVALID, 16'd0, 16'd0, 16'd2}},
        '{4'd2, 64'hc341,           1'b1, '{STATUS_INVALID, 16'd0, 16'd0, 16'd2}},
        '{4'd3, 64'h41e282,         1'b1, '{STATUS_INVALID, 16'd0, 16'd0, 16'd3}}
    };

    utf8_validate_whitespace_trim_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .trim_begin   (trim_begin),
        .trim_end     (trim_end),
        .total_length (total_length)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic logic [15:0] clamp_offset(input logic [17:0] v);
        return (v > LEN_MAX) ? 16'hffff : v[15:0];
    endfunction

    task automatic clear_decoder();
        cont_left    = 2'd0;
        seq_width    = SEQ_NONE;
        cp_value     = 21'd0;
        cp_start     = 16'd0;
        bytes_seen   = 17'd0;
        first_begin  = 16'd0;
        last_end     = 16'd0;
        any_nonspace = 1'b0;
        bad_utf8     = 1'b0;
    endtask

    task automatic close_codepoint(input logic [17:0] end_pos);
        logic blank;
        case (cp_value)
            21'h85, 21'ha0, 21'h1680, 21'h2028, 21'h2029, 21'h202f, 21'h205f, 21'h3000:
                blank = 1'b1;
            default:
                blank = (cp_value >= 21'h9 && cp_value <= 21'hd) ||
                        (cp_value >= 21'h1c && cp_value <= 21'h20) ||
                        (cp_value >= 21'h2000 && cp_value <= 21'h200a);
        endcase
        if ((seq_width == SEQ_W3 && cp_value < CP_MIN3) ||
            (seq_width == SEQ_W4 && cp_value < CP_MIN4) ||
            cp_value > CP_MAX || (cp_value >= CP_SURR_LO && cp_value <= CP_SURR_HI))
        begin
            bad_utf8 = 1'b1;
        end
        else if (!blank)
        begin
            if (!any_nonspace)
                first_begin = cp_start;
            any_nonspace = 1'b1;
            last_end     = clamp_offset(end_pos);
        end
    endtask

    // Advances the decoder by one accepted byte; on the final byte it hands back the report.
    task automatic decode_and_trim(input logic [7:0] b, input logic fin,
                                   output logic produced, output result_t rpt);
        logic [17:0] pos;
        logic [15:0] len;
        pos      = {1'b0, bytes_seen};
        produced = 1'b0;
        rpt      = NO_REPORT;
        if (!bad_utf8)
        begin
            if (cont_left == 2'd0)
            begin
                cp_start = clamp_offset(pos);
                if (b[7] == 1'b0)
                begin
                    seq_width = SEQ_W1;
                    cp_value  = {13'd0, b};
                    close_codepoint(pos + 18'd1);
                end
                else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
                begin
                    seq_width = SEQ_W2;
                    cp_value  = {16'd0, b[4:0]};
                    cont_left = 2'd1;
                end
                else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
                begin
                    seq_width = SEQ_W3;
                    cp_value  = {17'd0, b[3:0]};
                    cont_left = 2'd2;
                end
                else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
                begin
                    seq_width = SEQ_W4;
                    cp_value  = {18'd0, b[2:0]};
                    cont_left = 2'd3;
                end
                else
                begin
                    bad_utf8 = 1'b1;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                bad_utf8 = 1'b1;
            end
            else
            begin
                cp_value  = {cp_value[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                    close_codepoint(pos + 18'd1);
            end
        end
        // The count stops one past the largest length so that too long stays visible.
        if (bytes_seen <= LEN_MAX)
            bytes_seen = bytes_seen + 17'd1;
        if (fin)
        begin
            if (cont_left != 2'd0)
                bad_utf8 = 1'b1;
            len              = clamp_offset({1'b0, bytes_seen});
            produced         = 1'b1;
            rpt.total_length = len;
            if (bad_utf8)
            begin
                rpt.status = STATUS_INVALID;
            end
            else
            begin
                rpt.status     = (bytes_seen > LEN_MAX) ? STATUS_TOO_LONG : STATUS_OK;
                rpt.trim_begin = any_nonspace ? first_begin : len;
                rpt.trim_end   = any_nonspace ? last_end : len;
            end
            clear_decoder();
        end
    endtask

    task automatic push_codepoint(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            text_bytes.push_back(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            text_bytes.push_back({3'b110, cp[10:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            text_bytes.push_back({4'b1110, cp[15:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            text_bytes.push_back({5'b11110, cp[20:18]});
            text_bytes.push_back({2'b10, cp[17:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    function automatic logic [20:0] pick_codepoint(input logic want_space);
        int unsigned k;
        logic [20:0] cp;
        k = want_space ? $urandom_range(0, 1) : $urandom_range(2, 9);
        case (k)
            0:
            begin
                cp = 21'($urandom_range(0, 9));
                cp = (cp < 21'd5) ? cp + 21'h9 : cp + 21'h17;
            end
            1:
            begin
                case ($urandom_range(0, 7))
                    0: cp = 21'h85;
                    1: cp = 21'ha0;
                    2: cp = 21'h1680;
                    3: cp = 21'(21'h2000 + $urandom_range(0, 10));
                    4: cp = 21'(21'h2028 + $urandom_range(0, 1));
                    5: cp = 21'h202f;
                    6: cp = 21'h205f;
                    default: cp = 21'h3000;
                endcase
            end
            2, 3: cp = 21'($urandom_range(21'h21, 21'h7e));
            4:
            begin
                // Codepoints right next to the strip set.
                case ($urandom_range(0, 9))
                    0: cp = 21'($urandom_range(0, 8));
                    1: cp = 21'($urandom_range(21'he, 21'h1b));
                    2: cp = 21'(21'h84 + 2 * $urandom_range(0, 1));
                    3: cp = 21'(21'h9f + 2 * $urandom_range(0, 1));
                    4: cp = 21'(21'h167f + 2 * $urandom_range(0, 1));
                    5: cp = 21'(21'h1fff + 12 * $urandom_range(0, 1));
                    6: cp = 21'(21'h2027 + 3 * $urandom_range(0, 1));
                    7: cp = 21'(21'h202e + 2 * $urandom_range(0, 1));
                    8: cp = 21'(21'h205e + 2 * $urandom_range(0, 1));
                    default: cp = 21'(21'h2fff + 2 * $urandom_range(0, 1));
                endcase
            end
            5: cp = 21'($urandom_range(21'h80, 21'h7ff));
            6:
            begin
                cp = 21'($urandom_range(21'h800, 21'hffff));
                if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
                    cp = cp ^ 21'h2000;
            end
            7: cp = 21'($urandom_range(21'h10000, 21'h10ffff));
            default:
            begin
                case ($urandom_range(0, 9))
                    0: cp = 21'h0;
                    1: cp = 21'h7f;
                    2: cp = 21'h80;
                    3: cp = 21'h7ff;
                    4: cp = 21'h800;
                    5: cp = 21'hd7ff;
                    6: cp = 21'he000;
                    7: cp = 21'hffff;
                    8: cp = 21'h10000;
                    default: cp = 21'h10ffff;
                endcase
            end
        endcase
        return cp;
    endfunction

    // Leading blanks, a mixed body and trailing blanks, so the trim bounds move around.
    task automatic build_clean_text();
        int unsigned lead_n;
        int unsigned body_n;
        int unsigned tail_n;
        text_bytes.delete();
        lead_n = $urandom_range(0, 3);
        body_n = $urandom_range(0, 6);
        tail_n = $urandom_range(0, 3);
        if (lead_n + body_n + tail_n == 0)
            body_n = 1;
        repeat (lead_n) push_codepoint(pick_codepoint(1'b1));
        repeat (body_n) push_codepoint(pick_codepoint($urandom_range(0, 4) == 0));
        repeat (tail_n) push_codepoint(pick_codepoint(1'b1));
    endtask

    // Sends the whole of text_bytes as one string, one request per byte.
    task automatic send_text();
        logic    produced;
        result_t rpt;
        for (int i = 0; i < text_bytes.size(); i++)
        begin
            if (sender_gaps && $urandom_range(0, 5) == 0)
            begin
                byte_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            byte_valid <= 1'b1;
            data_byte  <= text_bytes[i];
            last_byte  <= (i == text_bytes.size() - 1);
            do
                @(posedge clk);
            while (!byte_ready);
            decode_and_trim(text_bytes[i], i == text_bytes.size() - 1, produced, rpt);
            if (produced)
                pending_reports.push_back(rpt);
            bytes_sent++;
        end
    endtask

    initial
    begin : result_sink
        int unsigned stall_left;
        result_t     want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result with no request pending: status %0d, length %0d",
                           status, total_length);
                    fail_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (status != want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (trim_begin != want.trim_begin)
                    begin
                        $error("trim_begin: expected %0d, got %0d", want.trim_begin, trim_begin);
                        fail_count++;
                    end
                    if (trim_end != want.trim_end)
                    begin
                        $error("trim_end: expected %0d, got %0d", want.trim_end, trim_end);
                        fail_count++;
                    end
                    if (total_length != want.total_length)
                    begin
                        $error("total_length: expected %0d, got %0d",
                               want.total_length, total_length);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES - 1;
                result_ready <= 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                stall_left   = $urandom_range(0, 13);
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned strings;
        noise_t      kind;
        clear_decoder();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            text_bytes.delete();
            for (int i = dir_table[r].nbytes - 1; i >= 0; i--)
                text_bytes.push_back(dir_table[r].text[8 * i +: 8]);
            send_text();
            // Rows with a hand-written report are checked against it instead.
            if (dir_table[r].typed)
                pending_reports[pending_reports.size() - 1] = dir_table[r].report;
        end

        sender_gaps = 1'b1;
        bytes_sent  = 0;
        strings     = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            // Hold results back for a long stretch while requests keep coming.
            if (strings == 12)
                hold_off_req = 1'b1;
            if (bytes_sent >= QUIET_AFTER)
            begin
                sender_gaps = 1'b0;
                sink_gaps   = 1'b0;
            end
            build_clean_text();
            if ($urandom_range(0, 5) == 0)
            begin
                kind = noise_t'($urandom_range(0, 3));
                case (kind)
                    NOISE_RAW:
                    begin
                        text_bytes.delete();
                        repeat ($urandom_range(1, 6))
                            text_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    NOISE_FLIP:
                        text_bytes[$urandom_range(0, text_bytes.size() - 1)] =
                            8'($urandom_range(0, 255));
                    NOISE_CUT:
                        if (text_bytes.size() > 1)
                            void'(text_bytes.pop_back());
                    default:
                    begin
                        case ($urandom_range(0, 5))
                            0:
                            begin
                                text_bytes.push_back(8'he0);
                                text_bytes.push_back(8'($urandom_range(8'h80, 8'h9f)));
                                text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
                            end
                            1:
                            begin
                                text_bytes.push_back(8'hf0);
                                text_bytes.push_back(8'($urandom_range(8'h80, 8'h8f)));
                                text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
                                text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
                            end
                            2:
                            begin
                                text_bytes.push_back(8'hed);
                                text_bytes.push_back(8'($urandom_range(8'ha0, 8'hbf)));
                                text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
                            end
                            3:
                            begin
                                text_bytes.push_back(8'hf4);
                                text_bytes.push_back(8'($urandom_range(8'h90, 8'hbf)));
                                text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
                                text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
                            end
                            4:
                            begin
                                if ($urandom_range(0, 1) == 0)
                                    text_bytes.push_back(8'($urandom_range(8'hc0, 8'hc1)));
                                else
                                    text_bytes.push_back(8'($urandom_range(8'hf5, 8'hff)));
                            end
                            default:
                                text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
                        endcase
                        push_codepoint(pick_codepoint(1'b0));
                    end
                endcase
            end
            send_text();
            strings++;
        end

        byte_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
